// ----- rtl/core/hdcfc_pkg.sv -----
// Package for the header-delimited CRC-16 frame checker.
// Holds shared constants, the result status codes, the result record and the CRC byte update.
// No dependencies; every other file of the block imports it.
`default_nettype none

package hdcfc_pkg;

  // Reset values of the start marker bytes.
  localparam logic [7:0] HEADER_FIRST_RST  = 8'h21;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h03;

  // CRC-16/MODBUS, reflected form.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame length limit and the width of the length field.
  localparam int unsigned MAX_FRAME_BYTES = 1024;
  localparam int unsigned COUNT_W         = 11;
  localparam logic [COUNT_W-1:0] MAX_LEN_CODE = COUNT_W'(MAX_FRAME_BYTES % (1 << COUNT_W));
  localparam logic [COUNT_W-1:0] LAST_COUNT   = COUNT_W'(MAX_FRAME_BYTES - 1);
  localparam logic [COUNT_W-1:0] SHORT_LIMIT  = COUNT_W'(2);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 1'b1;

  // Status of a closed frame.
  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_SHORT = 2'd1,
    ST_CRC   = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  // One result transaction.
  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   length;
  } result_t;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One byte through the reflected CRC: eight shift steps on a 16-bit value.
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hdcfc_out_fifo.sv -----
// Small result queue between the frame logic and the result channel.
// Depends on hdcfc_pkg for the result record and the queue geometry.
`default_nettype none

module hdcfc_out_fifo (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  input  wire hdcfc_pkg::result_t              push_data,
  input  wire logic                            pop,
  output hdcfc_pkg::result_t                   head,
  output logic                                 not_empty,
  output logic [hdcfc_pkg::FIFO_CW-1:0]        count
);
  import hdcfc_pkg::*;

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic                 do_pop;

  assign do_pop    = pop && (count_r != '0);
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  assign count     = count_r;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; entries are read only after being written.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/header_delimited_crc16_frame_checker.sv -----
// Header-delimited CRC-16/MODBUS frame checker, top level.
// Depends on hdcfc_pkg and hdcfc_out_fifo.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data_byte) carries one stream
//   byte per transaction. Bytes before the first start marker are skipped.
//   When a marker closes an open frame, one result transaction goes out on
//   (out_valid, out_stall, out_frame_status, out_frame_length): status 0 good,
//   1 too short, 2 CRC mismatch, 3 too long. A frame that reaches 1024 bytes
//   is reported as too long and the block hunts for the next marker.
//   The marker bytes are set through cfg_wr_en / cfg_index / cfg_wdata
//   (index 0 first byte, index 1 second byte) while the block is idle.
// Timing:
//   One byte is accepted per cycle while in_stall is low. A byte is registered,
//   then processed by the CRC and marker logic in the next cycle, and a result
//   is written into a result queue that drives the output. This four-entry
//   queue keeps input running while the receiver stalls; in_stall rises only
//   when the queued results plus the byte in flight would fill it.
// Reset:
//   rst_n is synchronous and active low. It clears the frame state, empties
//   the queue and restores the marker to 0x21 0x03.
`default_nettype none

module header_delimited_crc16_frame_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input stream
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [7:0]                         in_data_byte,
  // Results
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_frame_status,
  output logic [hdcfc_pkg::COUNT_W-1:0]           out_frame_length,
  // Configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic [hdcfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [7:0]                         cfg_wdata
);
  import hdcfc_pkg::*;

  logic [7:0]           header_first_r, header_second_r;
  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic [15:0]          crc_r, crc_nxt;
  logic [7:0]           held_byte_r, held_byte_nxt;
  logic                 held_valid_r, held_valid_nxt;
  logic                 in_frame_r, in_frame_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 marker;
  logic                 res_push;
  result_t              res_data;
  result_t              fifo_head;
  logic                 fifo_not_empty;
  logic [FIFO_CW-1:0]   fifo_count;
  logic                 in_accept;
  logic [FIFO_CW:0]     occupancy;

  // Stall when queued results plus the byte in flight leave no room.
  assign occupancy = {1'b0, fifo_count} + {{FIFO_CW{1'b0}}, s1_valid_r};
  assign in_stall  = (occupancy >= (FIFO_CW + 1)'(FIFO_DEPTH));
  assign in_accept = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= HEADER_FIRST_RST;
      header_second_r <= HEADER_SECOND_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  header_first_r  <= cfg_wdata;
        REG_HEADER_SECOND: header_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data_byte;
    end
  end

  // Frame logic for the registered byte.
  assign marker = held_valid_r && (held_byte_r == header_first_r)
                  && (s1_byte_r == header_second_r);

  always_comb begin
    crc_nxt        = crc_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    in_frame_nxt   = in_frame_r;
    count_nxt      = count_r;
    res_push       = 1'b0;
    res_data       = '{status: ST_GOOD, length: count_r};
    if (s1_valid_r) begin
      held_byte_nxt  = s1_byte_r;
      held_valid_nxt = 1'b1;
      if (marker) begin
        // A marker closes the open frame and starts a new one.
        if (in_frame_r) begin
          res_push = 1'b1;
          priority if (count_r <= SHORT_LIMIT) begin
            res_data.status = ST_SHORT;
          end else if (crc_r != 16'h0000) begin
            res_data.status = ST_CRC;
          end else begin
            res_data.status = ST_GOOD;
          end
        end
        in_frame_nxt = 1'b1;
        crc_nxt      = crc_add_byte(CRC_INIT, held_byte_r);
        count_nxt    = COUNT_W'(1);
      end else if (in_frame_r && held_valid_r) begin
        // Commit the held byte, or give up on an overlong frame.
        if (count_r >= LAST_COUNT) begin
          res_push     = 1'b1;
          res_data     = '{status: ST_LONG, length: MAX_LEN_CODE};
          in_frame_nxt = 1'b0;
          count_nxt    = '0;
          crc_nxt      = CRC_INIT;
        end else begin
          crc_nxt   = crc_add_byte(crc_r, held_byte_r);
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= CRC_INIT;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      in_frame_r   <= 1'b0;
      count_r      <= '0;
    end else begin
      crc_r        <= crc_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      in_frame_r   <= in_frame_nxt;
      count_r      <= count_nxt;
    end
  end

  // Result queue and output channel.
  hdcfc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .pop       (!out_stall),
    .head      (fifo_head),
    .not_empty (fifo_not_empty),
    .count     (fifo_count)
  );

  assign out_valid        = fifo_not_empty;
  assign out_frame_status = fifo_head.status;
  assign out_frame_length = fifo_head.length;

endmodule

`default_nettype wire

// ----- rtl/core/hdcfc_checker.sv -----
// Port-level checks for the header-delimited CRC-16 frame checker.
// Depends on hdcfc_pkg; bound to the top level at the end of this file.
`default_nettype none

module hdcfc_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [1:0]                         out_frame_status,
  input wire logic [hdcfc_pkg::COUNT_W-1:0]      out_frame_length
);
  import hdcfc_pkg::*;

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_status)
                               && $stable(out_frame_length))
    else $error("result transaction changed while stalled");

  // No result right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An overlong frame always reports the limit as its length.
  a_long_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_LONG |-> out_frame_length == MAX_LEN_CODE)
    else $error("too-long frame with wrong length");

  // Good and CRC-mismatch frames are longer than two bytes.
  a_judged_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status == ST_GOOD || out_frame_status == ST_CRC)
    |-> out_frame_length > SHORT_LIMIT)
    else $error("judged frame shorter than three bytes");

  // A short frame has one or two bytes.
  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_SHORT
    |-> out_frame_length <= SHORT_LIMIT && out_frame_length != '0)
    else $error("short frame with bad length");

endmodule

bind header_delimited_crc16_frame_checker hdcfc_checker u_hdcfc_checker (.*);

`default_nettype wire

// ----- sim/tb_header_delimited_crc16_frame_checker.sv -----
// Self-checking testbench for the header-delimited CRC-16/MODBUS frame checker.
// Streams directed and random byte sequences under several marker settings and compares
// every frame report against a built-in predictor. Depends on hdcfc_pkg and the block.
`timescale 1ns / 100ps

module tb_header_delimited_crc16_frame_checker;
  import hdcfc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_frame_status;
  logic [COUNT_W-1:0]   out_frame_length;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER_FIRST;
  logic [7:0]           cfg_wdata = 8'h00;

  header_delimited_crc16_frame_checker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_status (out_frame_status),
    .out_frame_length (out_frame_length),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Stream bytes waiting to be sent, and frame reports the predictor has produced.
  logic [7:0]  pending_bytes[$];
  result_t     expected_reports[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches = 0;

  // Predictor copy of the marker registers and the frame state.
  logic [7:0]  mark_first = HEADER_FIRST_RST;
  logic [7:0]  mark_second = HEADER_SECOND_RST;
  logic [15:0] crc_acc = CRC_INIT;
  logic [7:0]  last_byte = 8'h00;
  logic        last_ok = 1'b0;
  logic        collecting = 1'b0;
  int unsigned frame_bytes = 0;

  // Idle behavior of both sides, chosen per phase.
  bit in_busy = 1'b1;
  bit out_busy = 1'b1;
  int in_gap = 0;
  int out_hold = 0;
  bit in_taken = 1'b0;

  // Reflected CRC-16, one data bit at a time.
  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Mostly short gaps, now and then a long one; none at all when the side is busy-free.
  function automatic int pick_delay(input bit enabled);
    int r;
    if (!enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // Advance the predicted frame state by one accepted byte.
  task automatic track_stream_byte(input logic [7:0] b);
    result_t rpt;
    if (last_ok && last_byte == mark_first && b == mark_second) begin
      // A complete marker closes the open frame and starts a new one.
      if (collecting) begin
        if (frame_bytes <= 2) begin
          rpt.status = ST_SHORT;
        end else if (crc_acc != 16'h0000) begin
          rpt.status = ST_CRC;
        end else begin
          rpt.status = ST_GOOD;
        end
        rpt.length = COUNT_W'(frame_bytes);
        expected_reports.push_back(rpt);
      end
      collecting  = 1'b1;
      crc_acc     = crc16_update(CRC_INIT, last_byte);
      frame_bytes = 1;
    end else if (collecting && last_ok) begin
      // Commit the held byte, unless the frame would reach the length limit.
      if (frame_bytes + 1 >= MAX_FRAME_BYTES) begin
        rpt.status = ST_LONG;
        rpt.length = COUNT_W'(MAX_FRAME_BYTES);
        expected_reports.push_back(rpt);
        collecting  = 1'b0;
        frame_bytes = 0;
        crc_acc     = CRC_INIT;
      end else begin
        crc_acc     = crc16_update(crc_acc, last_byte);
        frame_bytes = frame_bytes + 1;
      end
    end
    last_byte = b;
    last_ok   = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Marker, random payload and trailing CRC; optionally one bit flipped after the marker.
  task automatic send_frame(input int payload_len, input bit corrupt);
    logic [7:0]  fr[$];
    logic [15:0] c;
    int          pos;
    fr.push_back(mark_first);
    fr.push_back(mark_second);
    repeat (payload_len) fr.push_back(8'($urandom));
    c = CRC_INIT;
    foreach (fr[i]) c = crc16_update(c, fr[i]);
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    if (corrupt) begin
      pos = $urandom_range(2, fr.size() - 1);
      fr[pos] = fr[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    foreach (fr[i]) send_byte(fr[i]);
  endtask

  // Mostly well-formed frames, with damaged frames, bare markers and marker-rich noise.
  task automatic random_traffic(input int budget);
    int unsigned start;
    int          r;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        send_frame((r < 52) ? $urandom_range(0, 12) : $urandom_range(13, 60), 1'b0);
      end else if (r < 76) begin
        send_frame($urandom_range(0, 12), 1'b1);
      end else if (r < 84) begin
        send_byte(mark_first);
        send_byte(mark_second);
        if ($urandom_range(0, 1)) begin
          send_byte(8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: send_byte(mark_first);
            1: send_byte(mark_second);
            default: send_byte(8'($urandom));
          endcase
        end
      end
    end
  endtask

  // Write both marker registers while the block is idle.
  task automatic program_marker(input logic [7:0] f, input logic [7:0] s);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_HEADER_FIRST;
    cfg_wdata <= f;
    @(negedge clk);
    cfg_index <= REG_HEADER_SECOND;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mark_first  = f;
    mark_second = s;
  endtask

  // Block until every queued byte is taken and every predicted report has arrived.
  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || expected_reports.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Input driver: a new byte only once the current transaction is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (pending_bytes.size() != 0) begin
        in_valid     <= 1'b1;
        in_data_byte <= pending_bytes.pop_front();
        in_gap = pick_delay(in_busy);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input acceptance feeds the predictor.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      track_stream_byte(in_data_byte);
      bytes_accepted++;
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold = out_hold - 1;
    end else begin
      out_stall <= 1'b0;
      out_hold = pick_delay(out_busy);
    end
  end

  // Result monitor: each accepted report is compared with the oldest prediction.
  always @(posedge clk) begin : report_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected frame report: status %0d length %0d",
                   out_frame_status, out_frame_length);
        end
      end else begin
        want = expected_reports.pop_front();
        if (want.status !== out_frame_status || want.length !== out_frame_length) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("frame report mismatch: expected status %0d length %0d, got %0d %0d",
                     want.status, want.length, out_frame_status, out_frame_length);
          end
        end
      end
    end
  end

  // Stimulus: one phase per marker setting, each drained before the next register write.
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: program_marker(8'h00, 8'hFF);
        2: program_marker(8'hFF, 8'h00);
        3: program_marker(8'h5A, 8'h5A);
        4: program_marker(8'($urandom), 8'($urandom));
        5: program_marker(HEADER_FIRST_RST, HEADER_SECOND_RST);
        default: ;
      endcase
      in_busy  = (p != 2);
      out_busy = (p != 5);

      if (p == 0) begin
        // Skipped bytes, a broken marker, then good, too short, good and corrupted frames.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(mark_first);
        send_byte(8'h00);
        send_frame(2, 1'b0);
        send_byte(mark_first);
        send_byte(mark_second);
        send_frame(0, 1'b0);
        send_frame(1, 1'b1);
        send_byte(mark_first);
        send_byte(mark_second);
        // A frame that runs past the length limit.
        repeat (1030) send_byte(8'($urandom));
      end else if (p == 3) begin
        // Equal marker bytes: overlapping markers close one-byte frames.
        repeat (4) send_byte(mark_first);
      end
      random_traffic(40);

      wait_drained();
      repeat (6) @(negedge clk);
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (expected_reports.size() != 0) begin
      mismatches += expected_reports.size();
      $display("%0d predicted frame reports never arrived", expected_reports.size());
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
